// ===== rtl/bfm_pkg.sv =====
// shared types and constants of the tape-language machine
`default_nettype none

package bfm_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SUPPLY = 2'd3;

  // result codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OUTPUT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_AWAIT_IN = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BUDGET   = 3'd5;

  // command characters
  localparam logic [BYTE_W-1:0] CMD_INC   = 8'h2B; // +
  localparam logic [BYTE_W-1:0] CMD_DEC   = 8'h2D; // -
  localparam logic [BYTE_W-1:0] CMD_LEFT  = 8'h3C; // <
  localparam logic [BYTE_W-1:0] CMD_RIGHT = 8'h3E; // >
  localparam logic [BYTE_W-1:0] CMD_OUT   = 8'h2E; // .
  localparam logic [BYTE_W-1:0] CMD_IN    = 8'h2C; // ,
  localparam logic [BYTE_W-1:0] CMD_OPEN  = 8'h5B; // [
  localparam logic [BYTE_W-1:0] CMD_CLOSE = 8'h5D; // ]

  // commands executed per item before the run pauses
  localparam int unsigned BUDGET_W = 21;
  localparam logic [BUDGET_W-1:0] RUN_BUDGET = 21'h100000;

endpackage

`default_nettype wire

// ===== rtl/bfm_if.sv =====
// item channels of the tape-language machine
`default_nettype none

interface bfm_in_if;
  import bfm_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] item_byte;
  modport source (output valid, output kind, output item_byte, input ready);
  modport sink   (input valid, input kind, input item_byte, output ready);
endinterface

interface bfm_out_if;
  import bfm_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   out_byte;
  modport source (output valid, output status, output out_byte, input ready);
  modport sink   (input valid, input status, input out_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/bfm_ram.sv =====
// single-port-write, registered-read ram used for program store and tape
`default_nettype none

module bfm_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/brainfuck_machine_core.sv =====
// tape-language machine: loader, run sequencer, program store and tape
// append, clear and supply-with-no-run items post their result in the cycle after acceptance
// runs: each fetched program byte passes S_EXEC (program and tape ram read), then S_DECODE,
//   each byte visited in a bracket scan passes S_SCAN_RD and S_SCAN_CHK (a forward scan
//   that runs off the end stops in S_SCAN_RD), and S_EXEC posts an end or budget result
// one item at a time; the next item is taken once the result slot is free or draining
// reset: control clears at once, then a pass over all TAPE_DEPTH cells zeroes the tape
`default_nettype none

module brainfuck_machine_core #(
  parameter int unsigned TAPE_DEPTH    = 32768,
  parameter int unsigned PROGRAM_DEPTH = 4096
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bfm_in_if.sink    in_i,
  bfm_out_if.source out_o
);
  import bfm_pkg::*;

  localparam int unsigned TP_W  = $clog2(TAPE_DEPTH);
  localparam int unsigned PA_W  = $clog2(PROGRAM_DEPTH);
  localparam int unsigned LEN_W = $clog2(PROGRAM_DEPTH + 1);

  localparam logic [TP_W-1:0]  TP_LAST  = TP_W'(TAPE_DEPTH - 1);
  localparam logic [LEN_W-1:0] PROG_MAX = LEN_W'(PROGRAM_DEPTH);

  // sequencer states
  typedef enum logic [2:0] {
    S_CLR,      // zeroing the tape after reset
    S_IDLE,     // waiting for an item
    S_EXEC,     // end and budget checks, fetch of program byte and current cell
    S_DECODE,   // act on the fetched command
    S_SCAN_RD,  // bracket scan: read program byte at the scan index
    S_SCAN_CHK  // bracket scan: update nesting depth, stop or step on
  } state_e;

  // where a run stands between items
  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_PAUSED,
    MODE_INPUT
  } mode_e;

  state_e             state_q;
  mode_e              mode_q;
  logic [TP_W-1:0]    ptr_q;       // tape pointer
  logic [TP_W-1:0]    clr_addr_q;  // clearing pass address
  logic [LEN_W-1:0]   len_q;       // program length
  logic [LEN_W-1:0]   pc_q;        // next byte to fetch
  logic [LEN_W-1:0]   at_q;        // position of the byte being decoded
  logic [LEN_W-1:0]   scan_q;      // bracket scan index
  logic [LEN_W-1:0]   depth_q;     // bracket nesting depth during a scan
  logic               scan_back_q; // scan direction: backward for a closing bracket
  logic [BUDGET_W-1:0] budget_q;   // commands fetched in this item
  logic               out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [BYTE_W-1:0]  out_byte_q;

  logic [BYTE_W-1:0]  prog_rdata;
  logic [BYTE_W-1:0]  cur_cell;
  logic [BYTE_W-1:0]  cmd;

  // ---------------------------------------------------------------- handshake
  logic in_fire;
  logic out_fire;
  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = status_q;
  assign out_o.out_byte = out_byte_q;

  assign cmd = prog_rdata;

  // ---------------------------------------------------------------- program store
  logic             prog_we;
  logic [PA_W-1:0]  prog_raddr;

  // appends only land below the store size
  assign prog_we    = in_fire && (in_i.kind == KIND_APPEND) && (len_q < PROG_MAX);
  // fetch reads at the program counter, a scan reads at its own index
  assign prog_raddr = (state_q == S_EXEC) ? pc_q[PA_W-1:0] : scan_q[PA_W-1:0];

  bfm_ram #(
    .DEPTH (PROGRAM_DEPTH),
    .WIDTH (BYTE_W)
  ) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (len_q[PA_W-1:0]),
    .wdata_i (in_i.item_byte),
    .raddr_i (prog_raddr),
    .rdata_o (prog_rdata)
  );

  // ---------------------------------------------------------------- tape
  logic              tape_we;
  logic [TP_W-1:0]   tape_waddr;
  logic [BYTE_W-1:0] tape_wdata;
  logic              cell_arith;

  assign cell_arith = (state_q == S_DECODE) && ((cmd == CMD_INC) || (cmd == CMD_DEC));

  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = ptr_q;
    tape_wdata = in_i.item_byte;
    if (state_q == S_CLR) begin
      tape_we    = 1'b1;
      tape_waddr = clr_addr_q;
      tape_wdata = '0;
    end else if (cell_arith) begin
      tape_we    = 1'b1;
      tape_wdata = (cmd == CMD_INC) ? cur_cell + 8'd1 : cur_cell - 8'd1;
    end else if (in_fire && (in_i.kind == KIND_SUPPLY) && (mode_q == MODE_INPUT)) begin
      // input byte lands in the current cell before the run resumes
      tape_we = 1'b1;
    end
  end

  // the tape is read at the pointer every cycle; the pointer holds from fetch to decode
  bfm_ram #(
    .DEPTH (TAPE_DEPTH),
    .WIDTH (BYTE_W)
  ) u_tape_ram (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (ptr_q),
    .rdata_o (cur_cell)
  );

  // ---------------------------------------------------------------- bracket scan step
  logic [LEN_W-1:0] depth_nx;
  always_comb begin
    depth_nx = depth_q;
    if (cmd == CMD_OPEN) begin
      depth_nx = scan_back_q ? depth_q - 1'b1 : depth_q + 1'b1;
    end else if (cmd == CMD_CLOSE) begin
      depth_nx = scan_back_q ? depth_q + 1'b1 : depth_q - 1'b1;
    end
  end

  logic res_load;
  assign res_load = (state_q == S_IDLE && in_fire && !(in_i.kind == KIND_START ||
                     (in_i.kind == KIND_SUPPLY && mode_q != MODE_IDLE)))
                 || (state_q == S_EXEC && (pc_q >= len_q || budget_q == RUN_BUDGET))
                 || (state_q == S_DECODE && (cmd == CMD_OUT || cmd == CMD_IN));

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      mode_q      <= MODE_IDLE;
      ptr_q       <= '0;
      clr_addr_q  <= '0;
      len_q       <= '0;
      pc_q        <= '0;
      at_q        <= '0;
      scan_q      <= '0;
      depth_q     <= '0;
      scan_back_q <= 1'b0;
      budget_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_ACCEPTED;
      out_byte_q  <= '0;
    end else begin
      // a result posted in this cycle keeps the slot full
      if (out_fire && !res_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == TP_LAST) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_fire) begin
            budget_q <= '0;
            case (in_i.kind)
              KIND_APPEND: begin
                out_valid_q <= 1'b1;
                out_byte_q  <= '0;
                if (len_q < PROG_MAX) begin
                  len_q    <= len_q + 1'b1;
                  status_q <= ST_ACCEPTED;
                end else begin
                  status_q <= ST_FULL;
                end
              end
              KIND_CLEAR: begin
                len_q       <= '0;
                pc_q        <= '0;
                mode_q      <= MODE_IDLE;
                out_valid_q <= 1'b1;
                status_q    <= ST_ACCEPTED;
                out_byte_q  <= '0;
              end
              KIND_START: begin
                pc_q    <= '0;
                state_q <= S_EXEC;
              end
              default: begin
                // supply: resume a paused run, or report that none is active
                if (mode_q == MODE_IDLE) begin
                  out_valid_q <= 1'b1;
                  status_q    <= ST_FINISHED;
                  out_byte_q  <= '0;
                end else begin
                  state_q <= S_EXEC;
                end
              end
            endcase
          end
        end

        S_EXEC: begin
          if (pc_q >= len_q) begin
            mode_q      <= MODE_IDLE;
            out_valid_q <= 1'b1;
            status_q    <= ST_FINISHED;
            out_byte_q  <= '0;
            state_q     <= S_IDLE;
          end else if (budget_q == RUN_BUDGET) begin
            mode_q      <= MODE_PAUSED;
            out_valid_q <= 1'b1;
            status_q    <= ST_BUDGET;
            out_byte_q  <= '0;
            state_q     <= S_IDLE;
          end else begin
            budget_q <= budget_q + 1'b1;
            at_q     <= pc_q;
            pc_q     <= pc_q + 1'b1;
            state_q  <= S_DECODE;
          end
        end

        S_DECODE: begin
          case (cmd)
            CMD_LEFT: begin
              ptr_q   <= (ptr_q == '0) ? TP_LAST : ptr_q - 1'b1;
              state_q <= S_EXEC;
            end
            CMD_RIGHT: begin
              ptr_q   <= (ptr_q >= TP_LAST) ? '0 : ptr_q + 1'b1;
              state_q <= S_EXEC;
            end
            CMD_OUT: begin
              mode_q      <= MODE_PAUSED;
              out_valid_q <= 1'b1;
              status_q    <= ST_OUTPUT;
              out_byte_q  <= cur_cell;
              state_q     <= S_IDLE;
            end
            CMD_IN: begin
              mode_q      <= MODE_INPUT;
              out_valid_q <= 1'b1;
              status_q    <= ST_AWAIT_IN;
              out_byte_q  <= '0;
              state_q     <= S_IDLE;
            end
            CMD_OPEN: begin
              // zero cell: look forward from the next byte for the match
              if (cur_cell == '0) begin
                scan_q      <= pc_q;
                depth_q     <= LEN_W'(1);
                scan_back_q <= 1'b0;
                state_q     <= S_SCAN_RD;
              end else begin
                state_q <= S_EXEC;
              end
            end
            CMD_CLOSE: begin
              // nonzero cell: look backward; a bracket at position zero has no match
              if (cur_cell != '0 && at_q != '0) begin
                scan_q      <= at_q - 1'b1;
                depth_q     <= LEN_W'(1);
                scan_back_q <= 1'b1;
                state_q     <= S_SCAN_RD;
              end else begin
                state_q <= S_EXEC;
              end
            end
            default: begin
              // cell arithmetic is written through the tape port; other bytes do nothing
              state_q <= S_EXEC;
            end
          endcase
        end

        S_SCAN_RD: begin
          // forward scan running off the end leaves the bracket unmatched
          if (!scan_back_q && scan_q >= len_q) begin
            state_q <= S_EXEC;
          end else begin
            state_q <= S_SCAN_CHK;
          end
        end

        S_SCAN_CHK: begin
          depth_q <= depth_nx;
          if (depth_nx == '0) begin
            pc_q    <= scan_q + 1'b1;
            state_q <= S_EXEC;
          end else if (scan_back_q) begin
            if (scan_q == '0) begin
              state_q <= S_EXEC;
            end else begin
              scan_q  <= scan_q - 1'b1;
              state_q <= S_SCAN_RD;
            end
          end else begin
            scan_q  <= scan_q + 1'b1;
            state_q <= S_SCAN_RD;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- assertions
  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || out_o.ready))
    else $error("result posted over a pending result");

  // no item is taken while the tape is being cleared
  a_clr_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !in_i.ready)
    else $error("item accepted during tape clearing");

  // the program counter never passes the program length
  a_pc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= len_q)
    else $error("program counter beyond program length");

  // an output byte is shown only with the output status
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_OUTPUT) |-> (out_byte_q == '0))
    else $error("nonzero byte on a non-output result");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench of the tape-language machine: directed table, random programs, scoreboard
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bfm_pkg::*;

  localparam int unsigned TAPE_DEPTH    = 32768;
  localparam int unsigned PROGRAM_DEPTH = 4096;
  localparam int unsigned RANDOM_ITEMS  = 1520;

  // one result item of the block
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   out_byte;
  } result_t;

  // one row of the directed table, repeated reps times
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    int                reps;
    bit                typed;
    result_t           res;
  } stim_row_t;

  // where the machine stands between items
  typedef enum logic [1:0] {RUN_IDLE, RUN_PAUSED, RUN_INPUT} run_state_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bfm_in_if  in_if ();
  bfm_out_if out_if ();

  brainfuck_machine_core #(
    .TAPE_DEPTH   (TAPE_DEPTH),
    .PROGRAM_DEPTH(PROGRAM_DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // machine state as the testbench tracks it
  logic [BYTE_W-1:0] tape_cells [TAPE_DEPTH];
  logic [BYTE_W-1:0] prog_bytes [PROGRAM_DEPTH];
  int unsigned       head;
  int unsigned       prog_len;
  int unsigned       prog_pc;
  run_state_e        run_state;

  result_t           pending_results [$];
  stim_row_t         directed_rows [$];
  logic [BYTE_W-1:0] draft_bytes [$];
  int                fail_count = 0;
  int                busy_items = 0;
  int                idle_pct = 29;

  // executes from prog_pc until an output, an input, the end or the budget
  function automatic void run_machine(output logic [STATUS_W-1:0] st,
                                      output logic [BYTE_W-1:0] ob);
    int unsigned       steps;
    int unsigned       at;
    int unsigned       j;
    int                depth;
    logic [BYTE_W-1:0] c;
    bit                paused;
    steps  = 0;
    ob     = '0;
    st     = ST_FINISHED;
    paused = 1'b0;
    while (!paused && prog_pc < prog_len) begin
      if (steps >= RUN_BUDGET) begin
        run_state = RUN_PAUSED;
        st        = ST_BUDGET;
        paused    = 1'b1;
      end else begin
        steps++;
        at      = prog_pc;
        c       = prog_bytes[at];
        prog_pc = at + 1;
        case (c)
          CMD_INC:   tape_cells[head] = tape_cells[head] + 8'd1;
          CMD_DEC:   tape_cells[head] = tape_cells[head] - 8'd1;
          CMD_LEFT:  head = (head == 0) ? TAPE_DEPTH - 1 : head - 1;
          CMD_RIGHT: head = (head >= TAPE_DEPTH - 1) ? 0 : head + 1;
          CMD_OUT: begin
            ob        = tape_cells[head];
            run_state = RUN_PAUSED;
            st        = ST_OUTPUT;
            paused    = 1'b1;
          end
          CMD_IN: begin
            run_state = RUN_INPUT;
            st        = ST_AWAIT_IN;
            paused    = 1'b1;
          end
          CMD_OPEN: begin
            // zero cell: skip past the matching close, nothing if unmatched
            if (tape_cells[head] == 0) begin
              depth = 0;
              for (j = at; j < prog_len; j++) begin
                if (prog_bytes[j] == CMD_OPEN) depth++;
                else if (prog_bytes[j] == CMD_CLOSE) depth--;
                if (depth == 0) begin
                  prog_pc = j + 1;
                  break;
                end
              end
            end
          end
          CMD_CLOSE: begin
            // nonzero cell: back to just after the matching open
            if (tape_cells[head] != 0) begin
              depth = 0;
              j     = at + 1;
              while (j > 0) begin
                j--;
                if (prog_bytes[j] == CMD_CLOSE) depth++;
                else if (prog_bytes[j] == CMD_OPEN) depth--;
                if (depth == 0) begin
                  prog_pc = j + 1;
                  break;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
    if (!paused) run_state = RUN_IDLE;
  endfunction

  // updates the tracked state for one accepted item and gives its result
  function automatic void predict_item(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b,
                                       output result_t r);
    r = '0;
    case (k)
      KIND_APPEND: begin
        if (prog_len >= PROGRAM_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          prog_bytes[prog_len] = b;
          prog_len++;
        end
      end
      KIND_CLEAR: begin
        prog_len  = 0;
        prog_pc   = 0;
        run_state = RUN_IDLE;
      end
      KIND_START: begin
        prog_pc = 0;
        run_machine(r.status, r.out_byte);
      end
      default: begin
        if (run_state == RUN_IDLE) begin
          r.status = ST_FINISHED;
        end else begin
          if (run_state == RUN_INPUT) tape_cells[head] = b;
          run_machine(r.status, r.out_byte);
        end
      end
    endcase
  endfunction

  // offers one item, waits for its acceptance and files its expected result
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b,
                           input bit typed, input result_t typed_res);
    result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= k;
    in_if.item_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    busy_items++;
    predict_item(k, b, r);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // a byte that moves no bracket: commands, pointer moves, or any other byte
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    case ($urandom_range(7))
      0: b = CMD_INC;
      1: b = CMD_DEC;
      2: b = CMD_LEFT;
      3: b = CMD_RIGHT;
      4: b = CMD_OUT;
      5: b = CMD_IN;
      6: b = CMD_INC;
      default: begin
        b = BYTE_W'($urandom_range(255));
        if (b == CMD_OPEN || b == CMD_CLOSE) b = ~b;
      end
    endcase
    return b;
  endfunction

  // a loop body byte: never moves the pointer, never a bracket
  function automatic logic [BYTE_W-1:0] body_byte();
    logic [BYTE_W-1:0] b;
    case ($urandom_range(4))
      0: b = CMD_INC;
      1: b = CMD_DEC;
      2: b = CMD_OUT;
      3: b = CMD_IN;
      default: begin
        b = BYTE_W'($urandom_range(255));
        if (b == CMD_OPEN || b == CMD_CLOSE || b == CMD_LEFT || b == CMD_RIGHT) b = 8'h00;
      end
    endcase
    return b;
  endfunction

  // well-formed program: each loop counts its own cell down once per pass and only
  // touches its right neighbour otherwise, so every loop ends within 255 passes
  function automatic void build_program();
    int segs;
    int n;
    draft_bytes.delete();
    segs = $urandom_range(1, 6);
    repeat (segs) begin
      if ($urandom_range(99) < 60) begin
        n = $urandom_range(1, 4);
        repeat (n) draft_bytes.push_back(plain_byte());
      end else begin
        draft_bytes.push_back(CMD_OPEN);
        draft_bytes.push_back(CMD_DEC);
        draft_bytes.push_back(CMD_RIGHT);
        n = $urandom_range(0, 4);
        repeat (n) draft_bytes.push_back(body_byte());
        if ($urandom_range(99) < 30) begin
          // nested clearing loop on the neighbour cell
          draft_bytes.push_back(CMD_OPEN);
          draft_bytes.push_back(CMD_DEC);
          draft_bytes.push_back(CMD_CLOSE);
        end
        draft_bytes.push_back(CMD_LEFT);
        draft_bytes.push_back(CMD_CLOSE);
      end
    end
  endfunction

  // loads the draft, starts it and feeds the run a while, mixing in restarts,
  // appends to the paused program and clears in the middle of a run
  task automatic load_and_run(input bit clear_first);
    int cap;
    int pick;
    if (clear_first) send_item(KIND_CLEAR, BYTE_W'($urandom_range(255)), 1'b0, '0);
    foreach (draft_bytes[i]) send_item(KIND_APPEND, draft_bytes[i], 1'b0, '0);
    send_item(KIND_START, BYTE_W'($urandom_range(255)), 1'b0, '0);
    cap = $urandom_range(4, 40);
    for (int i = 0; i < cap && run_state != RUN_IDLE; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) send_item(KIND_APPEND, plain_byte(), 1'b0, '0);
      else if (pick < 12) send_item(KIND_START, BYTE_W'($urandom_range(255)), 1'b0, '0);
      else if (pick < 15) send_item(KIND_CLEAR, BYTE_W'($urandom_range(255)), 1'b0, '0);
      else send_item(KIND_SUPPLY, BYTE_W'($urandom_range(255)), 1'b0, '0);
    end
  endtask

  function automatic void add_row(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b,
                                  input int reps, input bit typed,
                                  input logic [STATUS_W-1:0] st, input logic [BYTE_W-1:0] ob);
    stim_row_t row;
    row.kind         = k;
    row.data         = b;
    row.reps         = reps;
    row.typed        = typed;
    row.res.status   = st;
    row.res.out_byte = ob;
    directed_rows.push_back(row);
  endfunction

  // scoreboard on the result side, plus random back-pressure
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: status %0d out_byte %0h",
                 out_if.status, out_if.out_byte);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_if.status);
            fail_count++;
          end
          if (out_if.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, out_if.out_byte);
            fail_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin : stimulus
    int   start_items;
    int   sel;
    int   cut;
    int   n;
    bit   drop_open;
    logic [KIND_W-1:0] k;
    logic [BYTE_W-1:0] b;

    in_if.valid     = 1'b0;
    in_if.kind      = KIND_APPEND;
    in_if.item_byte = '0;
    out_if.ready    = 1'b0;

    // state after reset: tape zero, no program, no run
    for (int i = 0; i < TAPE_DEPTH; i++) tape_cells[i] = '0;
    for (int i = 0; i < PROGRAM_DEPTH; i++) prog_bytes[i] = '0;
    head      = 0;
    prog_len  = 0;
    prog_pc   = 0;
    run_state = RUN_IDLE;

    // directed table: kind, byte, repeat, typed, expected status, expected byte
    // start with nothing loaded, supply with no run
    add_row(KIND_START,  8'h00, 1, 1'b1, ST_FINISHED, 8'h00);
    add_row(KIND_SUPPLY, 8'hFF, 1, 1'b1, ST_FINISHED, 8'h00);
    // program: 00 FF < , . + . > - . ] + [ .
    add_row(KIND_APPEND, 8'h00,     1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, 8'hFF,     1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_LEFT,  1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_IN,    1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_OUT,   1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_INC,   1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_OUT,   1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_RIGHT, 1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_DEC,   1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_OUT,   1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_CLOSE, 1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_INC,   1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_OPEN,  1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_OUT,   1, 1'b1, ST_ACCEPTED, 8'h00);
    // pointer wraps down to the last cell, which then waits for input
    add_row(KIND_START,  8'h00, 1, 1'b1, ST_AWAIT_IN, 8'h00);
    add_row(KIND_SUPPLY, 8'hFF, 1, 1'b1, ST_OUTPUT, 8'hFF);
    // byte ignored after an output pause; 255 + 1 wraps to zero
    add_row(KIND_SUPPLY, 8'h00, 1, 1'b1, ST_OUTPUT, 8'h00);
    // pointer wraps back up to cell 0; 0 - 1 wraps to 255
    add_row(KIND_SUPPLY, 8'h5A, 1, 1'b1, ST_OUTPUT, 8'hFF);
    // unmatched close on a nonzero cell, then unmatched open on a zero cell
    add_row(KIND_SUPPLY, 8'hA5, 1, 1'b1, ST_OUTPUT, 8'h00);
    add_row(KIND_SUPPLY, 8'h00, 1, 1'b1, ST_FINISHED, 8'h00);
    // endless loop: pauses on the budget, then a clear ends the paused run
    add_row(KIND_CLEAR,  8'h00,     1, 1'b1, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_INC,   1, 1'b0, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_OPEN,  1, 1'b0, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_RIGHT, 1, 1'b0, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_INC,   1, 1'b0, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_LEFT,  1, 1'b0, ST_ACCEPTED, 8'h00);
    add_row(KIND_APPEND, CMD_CLOSE, 1, 1'b0, ST_ACCEPTED, 8'h00);
    add_row(KIND_START,  8'h00,     1, 1'b1, ST_BUDGET, 8'h00);
    add_row(KIND_CLEAR,  8'hFF,     1, 1'b1, ST_ACCEPTED, 8'h00);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the block clears its tape after reset; send_item simply waits for ready
    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps)
        send_item(directed_rows[r].kind, directed_rows[r].data,
                  directed_rows[r].typed, directed_rows[r].res);
    end

    // random part: mostly well-formed programs with random content, the rest
    // truncated programs, noise with a single bracket kind and loose single items
    start_items = busy_items;
    while (busy_items < start_items + RANDOM_ITEMS) begin
      // a long stretch with neither side idling
      if (busy_items >= start_items + 600 && busy_items < start_items + 850) idle_pct = 0;
      else idle_pct = 29;
      sel = $urandom_range(99);
      if (sel < 65) begin
        // sometimes append to the loaded program instead of clearing first
        build_program();
        load_and_run(prog_len > 150 || $urandom_range(4) != 0);
      end else if (sel < 77) begin
        // a prefix of a well-formed program: may leave an open bracket unmatched
        build_program();
        cut = $urandom_range(1, draft_bytes.size());
        while (draft_bytes.size() > cut) void'(draft_bytes.pop_back());
        load_and_run(1'b1);
      end else if (sel < 90) begin
        // random bytes with only one bracket kind, so no loop can form
        draft_bytes.delete();
        drop_open = 1'($urandom_range(1));
        n = $urandom_range(1, 24);
        repeat (n) begin
          b = BYTE_W'($urandom_range(255));
          if (drop_open && b == CMD_OPEN) b = CMD_CLOSE;
          if (!drop_open && b == CMD_CLOSE) b = CMD_OPEN;
          draft_bytes.push_back(b);
        end
        load_and_run(1'b1);
      end else begin
        k = KIND_W'($urandom_range(3));
        b = BYTE_W'($urandom_range(255));
        if (k == KIND_APPEND && (b == CMD_OPEN || b == CMD_CLOSE)) b = ~b;
        send_item(k, b, 1'b0, '0);
      end
    end
    idle_pct = 29;
    in_if.valid <= 1'b0;

    // drain, then allow a margin for any stray result
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit for the whole simulation; a budget pause needs RUN_BUDGET commands to be fetched
  initial begin : watchdog
    #1_000_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
